// ----- sv/rpn_pkg.sv -----
// Shared constants and types for the RPN stack calculator.
package rpn_pkg;

    localparam int DATA_W          = 32;
    localparam int OP_W            = 3;
    localparam int STATUS_W        = 3;
    localparam int COUNT_W         = 7;
    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVER    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADOP   = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_UP,
        CELL_TAKE_DN
    } cell_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- sv/rpn_cell.sv -----
// One stack cell: holds an entry and trades it with its neighbors.
module rpn_cell
    import rpn_pkg::*;
(
    input  logic              aclk,
    input  cell_cmd_t         cmd,
    input  logic [DATA_W-1:0] up_in,
    input  logic [DATA_W-1:0] dn_in,
    output logic [DATA_W-1:0] val
);

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;

    always_comb begin
        case (cmd)
            CELL_TAKE_UP: val_next = up_in;
            CELL_TAKE_DN: val_next = dn_in;
            default:      val_next = val_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ----- sv/rpn_div.sv -----
// Iterative signed floor divider, one quotient bit per cycle.
module rpn_div
    import rpn_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DATA_W-1:0] num,
    input  logic [DATA_W-1:0] den,
    output div_stat_t         stat,
    output logic [DATA_W-1:0] quo
);

    localparam int BIT_W = $clog2(DATA_W);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_t;

    dstate_t           state_reg, state_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] q_reg, q_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] q_neg;

    assign trial = {rem_reg, q_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign q_neg = '0 - q_reg;

    always_comb begin
        state_next = state_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            D_IDLE: begin
                if (start) begin
                    q_next     = num[DATA_W-1] ? ('0 - num) : num;
                    den_next   = den[DATA_W-1] ? ('0 - den) : den;
                    neg_next   = num[DATA_W-1] ^ den[DATA_W-1];
                    rem_next   = '0;
                    bit_next   = BIT_W'(DATA_W - 1);
                    state_next = D_RUN;
                end
            end
            D_RUN: begin
                if (!diff[DATA_W]) begin
                    rem_next = diff[DATA_W-1:0];
                    q_next   = {q_reg[DATA_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[DATA_W-1:0];
                    q_next   = {q_reg[DATA_W-2:0], 1'b0};
                end
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0) begin
                    state_next = D_FIX;
                end
            end
            D_FIX: begin
                if (neg_reg) begin
                    q_next = (rem_reg != '0) ? (q_neg - 1'b1) : q_neg;
                end
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        bit_reg <= bit_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign stat.busy = (state_reg != D_IDLE);
    assign stat.done = done_reg;
    assign quo       = q_reg;

endmodule

// ----- sv/rpn_stack_calculator_top.sv -----
// RPN stack calculator top level: token sequencer, cell stack and divider.
// Usage:
//   Input channel s_*: one token per beat (push, add, sub, mul, floor div).
//   Result channel m_*: one beat per token with top of stack, depth, status
//   and the end marker copied through.
//   Push, add, subtract, multiply and every error pass from accept through
//   the execute and done states to the result; a divide also waits in the
//   divide state on the divider, which resolves one quotient bit per cycle.
//   One token is worked at a time; a new token is not accepted until the
//   previous one has left the done state. The next token can be taken
//   while the previous result still waits in the output register.
//   The stack is a row of cells, the top in the first cell; a push shifts
//   the row down, an operator loads the first cell and shifts the rest up.
//   Reset empties the stack at once (depth count to zero); cell contents
//   are not cleared.
//   When the receiver stalls, the result holds on m_* and the next token
//   completes its work, then waits until the output register frees up.
//   A token with the end marker reports the stack, then empties it.
module rpn_stack_calculator_top
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [OP_W-1:0]            s_operation,
    input  logic signed [DATA_W-1:0]   s_operand_value,
    input  logic                       s_end_of_expression,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [DATA_W-1:0]   m_top_value,
    output logic [COUNT_W-1:0]         m_stack_count,
    output logic [STATUS_W-1:0]        m_status,
    output logic                       m_is_final
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_DONE} state_t;
    typedef enum logic [1:0] {ACT_NONE, ACT_PUSH, ACT_POP} act_t;

    state_t              state_reg, state_next;
    act_t                act_reg, act_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic                last_reg, last_next;
    logic [DATA_W-1:0]   res_reg, res_next;
    logic [STATUS_W-1:0] st_reg, st_next;

    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   m_top_reg, m_top_next;
    logic [COUNT_W-1:0]  m_cnt_reg, m_cnt_next;
    logic [STATUS_W-1:0] m_st_reg, m_st_next;
    logic                m_fin_reg, m_fin_next;

    logic [DATA_W-1:0]   cell_val [STACK_DEPTH];
    logic [DATA_W-1:0]   top_load;
    logic [DATA_W-1:0]   opa;
    logic [DATA_W-1:0]   opb;
    logic [DATA_W-1:0]   mul_lo;
    logic [CNT_W-1:0]    cnt_after;
    logic [CNT_W+COUNT_W-1:0] cnt_wide;
    logic                apply;
    logic                div_start;
    div_stat_t           div_stat;
    logic [DATA_W-1:0]   div_q;

    assign opb      = cell_val[0];
    assign opa      = cell_val[1];
    assign mul_lo   = opa * opb;
    assign top_load = (act_reg == ACT_PUSH) ? val_reg : res_reg;
    assign apply    = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    assign div_start = (state_reg == S_EXEC) && (op_reg == OP_DIV)
                       && (cnt_reg >= CNT_W'(2)) && (opb != '0);

    generate
        for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
            cell_cmd_t         cmd;
            logic [DATA_W-1:0] up_in;
            logic [DATA_W-1:0] dn_in;

            always_comb begin
                cmd = CELL_HOLD;
                if (apply && act_reg == ACT_PUSH) begin
                    cmd = CELL_TAKE_UP;
                end else if (apply && act_reg == ACT_POP) begin
                    cmd = (i == 0) ? CELL_TAKE_UP : CELL_TAKE_DN;
                end
            end

            if (i == 0) begin : g_top
                assign up_in = top_load;
            end else begin : g_mid
                assign up_in = cell_val[i-1];
            end

            if (i == STACK_DEPTH - 1) begin : g_bot
                assign dn_in = cell_val[i];
            end else begin : g_inner
                assign dn_in = cell_val[i+1];
            end

            rpn_cell u_cell (
                .aclk  (aclk),
                .cmd   (cmd),
                .up_in (up_in),
                .dn_in (dn_in),
                .val   (cell_val[i])
            );
        end
    endgenerate

    rpn_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (opa),
        .den     (opb),
        .stat    (div_stat),
        .quo     (div_q)
    );

    always_comb begin
        case (act_reg)
            ACT_PUSH: cnt_after = cnt_reg + 1'b1;
            ACT_POP:  cnt_after = cnt_reg - 1'b1;
            default:  cnt_after = cnt_reg;
        endcase
    end

    assign cnt_wide = {{COUNT_W{1'b0}}, cnt_after};

    always_comb begin
        state_next   = state_reg;
        act_next     = act_reg;
        cnt_next     = cnt_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        last_next    = last_reg;
        res_next     = res_reg;
        st_next      = st_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_top_next   = m_top_reg;
        m_cnt_next   = m_cnt_reg;
        m_st_next    = m_st_reg;
        m_fin_next   = m_fin_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_operation;
                    val_next   = s_operand_value;
                    last_next  = s_end_of_expression;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                act_next   = ACT_NONE;
                st_next    = ST_OK;
                res_next   = '0;
                state_next = S_DONE;
                if (op_reg == OP_PUSH) begin
                    if (cnt_reg == CNT_W'(STACK_DEPTH)) begin
                        st_next = ST_OVER;
                    end else begin
                        act_next = ACT_PUSH;
                    end
                end else if (op_reg > OP_DIV) begin
                    st_next = ST_BADOP;
                end else if (cnt_reg < CNT_W'(2)) begin
                    st_next = ST_UNDER;
                end else begin
                    case (op_reg)
                        OP_ADD: begin
                            res_next = opa + opb;
                            act_next = ACT_POP;
                        end
                        OP_SUB: begin
                            res_next = opa - opb;
                            act_next = ACT_POP;
                        end
                        OP_MUL: begin
                            res_next = mul_lo;
                            act_next = ACT_POP;
                        end
                        default: begin
                            if (opb == '0) begin
                                st_next = ST_DIVZERO;
                            end else begin
                                act_next   = ACT_POP;
                                state_next = S_DIV;
                            end
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    res_next   = div_q;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (apply) begin
                    m_valid_next = 1'b1;
                    m_cnt_next   = cnt_wide[COUNT_W-1:0];
                    m_st_next    = st_reg;
                    m_fin_next   = last_reg;
                    if (act_reg == ACT_NONE) begin
                        m_top_next = (cnt_reg != '0) ? cell_val[0] : '0;
                    end else begin
                        m_top_next = top_load;
                    end
                    cnt_next   = last_reg ? '0 : cnt_after;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            act_reg     <= ACT_NONE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            act_reg     <= act_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg    <= op_next;
        val_reg   <= val_next;
        last_reg  <= last_next;
        res_reg   <= res_next;
        st_reg    <= st_next;
        m_top_reg <= m_top_next;
        m_cnt_reg <= m_cnt_next;
        m_st_reg  <= m_st_next;
        m_fin_reg <= m_fin_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_top_value   = m_top_reg;
    assign m_stack_count = m_cnt_reg;
    assign m_status      = m_st_reg;
    assign m_is_final    = m_fin_reg;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_div_only_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> (state_reg == S_DIV))
        else $error("divider busy outside divide state");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_EXEC))
        else $error("accepted beat not executed");

    a_under_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_UNDER) |-> (m_stack_count < COUNT_W'(2)))
        else $error("underflow reported with enough operands");

endmodule

// ----- dv/rpn_stack_calculator_top_tb.sv -----
// Self-checking testbench for the RPN stack calculator: token driver, result monitor, predictor.
module rpn_stack_calculator_top_tb;
    import rpn_pkg::*;

    localparam int DEPTH = STACK_DEPTH_DEF;
    localparam int TIMEOUT_UNITS = 2_000_000;
    localparam int DRAIN_CYCLES = 60;

    localparam logic [OP_W-1:0] OP_BAD_FIRST = OP_DIV + 3'd1;
    localparam logic [OP_W-1:0] OP_BAD_LAST  = 3'd7;

    localparam logic [DATA_W-1:0] INT_MIN   = 32'h8000_0000;
    localparam logic [DATA_W-1:0] INT_MAX   = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] MINUS_ONE = 32'hffff_ffff;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
        logic              last;
    } token_t;

    typedef struct packed {
        logic [DATA_W-1:0]   top;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
        logic                is_final;
    } calc_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [OP_W-1:0]          s_operation = OP_PUSH;
    logic signed [DATA_W-1:0] s_operand_value = '0;
    logic                     s_end_of_expression = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_top_value;
    logic [COUNT_W-1:0]       m_stack_count;
    logic [STATUS_W-1:0]      m_status;
    logic                     m_is_final;

    token_t       pending_tokens[$];
    calc_result_t expected_results[$];

    logic [DATA_W-1:0] calc_stack [DEPTH];
    int                calc_depth = 0;
    int                plan_depth = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                mismatch_count = 0;

    rpn_stack_calculator_top #(.STACK_DEPTH(DEPTH)) dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_operation         (s_operation),
        .s_operand_value     (s_operand_value),
        .s_end_of_expression (s_end_of_expression),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_top_value         (m_top_value),
        .m_stack_count       (m_stack_count),
        .m_status            (m_status),
        .m_is_final          (m_is_final)
    );

    always #1 aclk = ~aclk;

    function automatic logic [DATA_W-1:0] floor_quotient(logic [DATA_W-1:0] num,
                                                         logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] mag_num;
        logic [DATA_W-1:0] mag_den;
        logic [DATA_W-1:0] quot;
        logic [DATA_W-1:0] rem;
        mag_num = num[DATA_W-1] ? -num : num;
        mag_den = den[DATA_W-1] ? -den : den;
        quot = mag_num / mag_den;
        rem  = mag_num % mag_den;
        if (num[DATA_W-1] != den[DATA_W-1]) begin
            quot = -quot;
            if (rem != '0) begin
                quot = quot - 1'b1;
            end
        end
        return quot;
    endfunction

    function automatic calc_result_t evaluate_token(token_t tok);
        calc_result_t res;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] acc;
        res.status = ST_OK;
        acc = '0;
        if (tok.op == OP_PUSH) begin
            if (calc_depth >= DEPTH) begin
                res.status = ST_OVER;
            end else begin
                calc_stack[calc_depth] = tok.value;
                calc_depth++;
            end
        end else if (tok.op > OP_DIV) begin
            res.status = ST_BADOP;
        end else if (calc_depth < 2) begin
            res.status = ST_UNDER;
        end else begin
            lhs = calc_stack[calc_depth-2];
            rhs = calc_stack[calc_depth-1];
            case (tok.op)
                OP_ADD: acc = lhs + rhs;
                OP_SUB: acc = lhs - rhs;
                OP_MUL: acc = lhs * rhs;
                default: begin
                    if (rhs == '0) begin
                        res.status = ST_DIVZERO;
                    end else begin
                        acc = floor_quotient(lhs, rhs);
                    end
                end
            endcase
            if (res.status == ST_OK) begin
                calc_stack[calc_depth-2] = acc;
                calc_depth--;
            end
        end
        res.top = (calc_depth != 0) ? calc_stack[calc_depth-1] : '0;
        res.count = COUNT_W'(calc_depth);
        res.is_final = tok.last;
        if (tok.last) begin
            calc_depth = 0;
        end
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(7))
            0: return '0;
            1: return 32'd1;
            2: return MINUS_ONE;
            3: return INT_MIN;
            4: return INT_MAX;
            5, 6: return DATA_W'($signed($urandom_range(200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_token(logic [OP_W-1:0] op, logic [DATA_W-1:0] value, logic last);
        token_t tok;
        tok.op = op;
        tok.value = value;
        tok.last = last;
        pending_tokens.push_back(tok);
        if (op == OP_PUSH && plan_depth < DEPTH) begin
            plan_depth++;
        end else if (op != OP_PUSH && op <= OP_DIV && plan_depth >= 2) begin
            plan_depth--;
        end
        if (last) begin
            plan_depth = 0;
        end
    endtask

    // Well-formed expression; with pushes_first all operands go in before any operator.
    task automatic add_expression(int operands, bit pushes_first);
        token_t exprn[$];
        token_t tok;
        int     left;
        int     held;
        left = operands;
        held = 0;
        while (left > 0 || held > 1) begin
            if (left > 0 && (held < 2 || pushes_first || $urandom_range(1) == 0)) begin
                tok.op = OP_PUSH;
                tok.value = pick_operand();
                left--;
                held++;
            end else begin
                tok.op = OP_W'($urandom_range(OP_DIV, OP_ADD));
                tok.value = $urandom;
                held--;
            end
            tok.last = 1'b0;
            exprn.push_back(tok);
        end
        exprn[exprn.size()-1].last = ($urandom_range(15) != 0);
        foreach (exprn[i]) begin
            add_token(exprn[i].op, exprn[i].value, exprn[i].last);
        end
    endtask

    task automatic add_noise(int n);
        repeat (n) begin
            add_token(OP_W'($urandom), $urandom, $urandom_range(7) == 0);
        end
    endtask

    task automatic run_phase(int send_pct, int stall_pct, int n_items);
        int pick;
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        add_expression(DEPTH + 2, 1'b1);
        while (pending_tokens.size() < n_items) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                add_expression($urandom_range(8, 1), 1'b0);
            end else if (pick < 82) begin
                add_expression($urandom_range(20, 9), $urandom_range(1));
            end else begin
                add_noise($urandom_range(5, 1));
            end
        end
        while (pending_tokens.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin : drive_tokens
        token_t tok;
        token_t next_tok;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                tok.op = s_operation;
                tok.value = s_operand_value;
                tok.last = s_end_of_expression;
                expected_results.push_back(evaluate_token(tok));
            end
            if (!s_valid || s_ready) begin
                if (pending_tokens.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_tok = pending_tokens.pop_front();
                    s_valid <= 1'b1;
                    s_operation <= next_tok.op;
                    s_operand_value <= next_tok.value;
                    s_end_of_expression <= next_tok.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_results
        calc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result beat: top=%0d count=%0d status=%0d final=%0b",
                             m_top_value, m_stack_count, m_status, m_is_final);
                end
            end else begin
                want = expected_results.pop_front();
                if (m_top_value !== want.top || m_stack_count !== want.count ||
                    m_status !== want.status || m_is_final !== want.is_final) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result mismatch: expected top=%0d count=%0d status=%0d final=%0b",
                                 $signed(want.top), want.count, want.status, want.is_final);
                        $display("                 actual   top=%0d count=%0d status=%0d final=%0b",
                                 m_top_value, m_stack_count, m_status, m_is_final);
                    end
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_token(OP_ADD, '0, 1'b0);
        add_token(OP_BAD_FIRST, INT_MAX, 1'b0);
        add_token(OP_BAD_LAST, INT_MIN, 1'b0);
        add_token(OP_PUSH, INT_MAX, 1'b0);
        add_token(OP_SUB, '0, 1'b0);
        add_token(OP_PUSH, 32'd1, 1'b0);
        add_token(OP_ADD, '0, 1'b0);
        add_token(OP_PUSH, MINUS_ONE, 1'b0);
        add_token(OP_DIV, '0, 1'b0);
        add_token(OP_PUSH, '0, 1'b0);
        add_token(OP_DIV, '0, 1'b0);
        add_token(OP_BAD_LAST - 3'd1, '0, 1'b1);
        add_token(OP_PUSH, DATA_W'(-7), 1'b0);
        add_token(OP_PUSH, 32'd2, 1'b0);
        add_token(OP_DIV, '0, 1'b0);
        add_token(OP_PUSH, INT_MIN, 1'b0);
        add_token(OP_PUSH, INT_MAX, 1'b0);
        add_token(OP_MUL, '0, 1'b0);
        add_token(OP_PUSH, DATA_W'(-8), 1'b0);
        add_token(OP_PUSH, 32'd2, 1'b0);
        add_token(OP_DIV, '0, 1'b0);
        add_token(OP_PUSH, 32'd7, 1'b0);
        add_token(OP_PUSH, DATA_W'(-2), 1'b0);
        add_token(OP_DIV, '0, 1'b0);
        add_token(OP_SUB, '0, 1'b1);

        run_phase(0, 0, 440);
        run_phase(62, 0, 440);
        run_phase(0, 62, 440);
        run_phase(13, 13, 440);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_UNITS);
        $display("FAILURE");
        $finish;
    end

endmodule
